// ===== hdl/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the bilinear height-map sampler: register
// indexes, reset values, job record passed from front to back, state types.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int GRID_SIDE_DEFAULT   = 256;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // job fields sized for the largest grid side (1024)
  localparam int ADDR_MAX_W  = 20;
  localparam int WIDTH_MAX_W = 11;

  localparam int CFG_IDX_W = 2;
  localparam int WT_W      = 17;
  localparam logic [WT_W-1:0] WT_ONE = 17'h10000;

  localparam logic [8:0]  GRID_WIDTH_RST     = 9'd256;
  localparam logic [30:0] HALF_EXTENT_RST    = 31'd8388608;
  localparam logic [31:0] CELLS_PER_UNIT_RST = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_HALF_EXTENT    = 2'd1,
    REG_CELLS_PER_UNIT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SPLIT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD1,
    B_RD2,
    B_RD3
  } back_state_t;

  typedef struct packed {
    logic [8:0]  grid_width;
    logic [30:0] half_extent;
    logic [31:0] cells_per_unit;
  } cfg_t;

  typedef struct packed {
    req_t                   kind;
    logic [ADDR_MAX_W-1:0]  addr;
    logic [31:0]            data;
    logic [WT_W-1:0]        wx;
    logic [WT_W-1:0]        wz;
    logic                   clamped;
    logic [WIDTH_MAX_W-1:0] width;
  } job_t;

endpackage

// ===== hdl/hbs_front.sv =====
// ----------------------------------------------------------------------------
// hbs_front
// Accepts items, scales query positions, splits them into cell and weight,
// forms the base address and queues one job per query and per in-range load.
// ----------------------------------------------------------------------------
module hbs_front #(
  parameter int GRID_SIDE = hbs_pkg::GRID_SIDE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [15:0]        load_index,
  input  logic signed [31:0] load_height,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_z,
  input  hbs_pkg::cfg_t      cfg,
  output logic               push,
  output hbs_pkg::job_t      job,
  input  logic               full
);
  import hbs_pkg::*;

  localparam int CW         = $clog2(GRID_SIDE);
  localparam int WW         = $clog2(GRID_SIDE + 1);
  localparam int BW         = CW + WW;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;

  typedef struct packed {
    logic [CW-1:0]   cix;
    logic [WT_W-1:0] wt;
    logic            clamp;
  } axis_t;

  front_state_t    state, state_next;
  req_t            kind_q;
  logic [15:0]     index_q;
  logic [31:0]     data_q;
  logic [33:0]     pos_x, pos_z;
  logic [63:0]     prod_x, prod_z;
  logic [CW-1:0]   cell_x, cell_z;
  logic [WT_W-1:0] wt_x, wt_z;
  logic            clamp_q;
  logic [WW-1:0]   w_eff;
  logic            accept;
  logic            index_ok;
  logic            scale_nz;
  axis_t           split_x, split_z;
  logic [BW-1:0]   base_full;

  function automatic axis_t split_axis(input logic neg, input logic [63:0] p,
                                       input logic [WW-1:0] w, input logic nz);
    axis_t       r;
    logic [31:0] c;
    logic [15:0] f;
    logic [31:0] wm1;
    c   = p[63:32];
    f   = p[31:16];
    wm1 = 32'(w) - 32'd1;
    if (neg) begin
      // below the grid: first cell, zero weight
      r.cix   = '0;
      r.wt    = '0;
      r.clamp = nz;
    end else if (c < wm1) begin
      r.cix   = c[CW-1:0];
      r.wt    = {1'b0, f};
      r.clamp = 1'b0;
    end else begin
      // past the last interior cell: edge sample, flag unless exactly on it
      r.cix   = CW'(w - WW'(2));
      r.wt    = WT_ONE;
      r.clamp = !((c == wm1) && (f == 16'd0));
    end
    return r;
  endfunction

  always_comb begin
    if (cfg.grid_width < 9'd2) begin
      w_eff = WW'(2);
    end else if (32'(cfg.grid_width) > 32'(GRID_SIDE)) begin
      w_eff = WW'(GRID_SIDE);
    end else begin
      w_eff = WW'(cfg.grid_width);
    end
  end

  assign accept   = start && (state == F_IDLE);
  assign index_ok = 32'(load_index) < 32'(GRID_DEPTH);
  assign scale_nz = |cfg.cells_per_unit;
  assign split_x  = split_axis(pos_x[33], prod_x, w_eff, scale_nz);
  assign split_z  = split_axis(pos_z[33], prod_z, w_eff, scale_nz);
  assign base_full = BW'(cell_z) * BW'(w_eff) + BW'(cell_x);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (req_t'(req_type) == REQ_QUERY) begin
            state_next = F_MUL;
          end else if (index_ok) begin
            state_next = F_PUSH;
          end
        end
      end
      F_MUL:   state_next = F_SPLIT;
      F_SPLIT: state_next = F_PUSH;
      F_PUSH: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != F_IDLE);
    push = (state == F_PUSH) && !full;
  end

  always_comb begin
    job.kind    = kind_q;
    job.data    = data_q;
    job.wx      = wt_x;
    job.wz      = wt_z;
    job.clamped = clamp_q;
    job.width   = WIDTH_MAX_W'(w_eff);
    if (kind_q == REQ_QUERY) begin
      job.addr = ADDR_MAX_W'(base_full);
    end else begin
      job.addr = ADDR_MAX_W'(index_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= req_t'(req_type);
      index_q <= load_index;
      data_q  <= load_height;
      pos_x   <= 34'(query_x) + 34'(cfg.half_extent);
      pos_z   <= 34'(query_z) + 34'(cfg.half_extent);
    end
    if (state == F_MUL) begin
      // a negative position never needs its product
      prod_x <= 64'(pos_x[31:0]) * 64'(cfg.cells_per_unit);
      prod_z <= 64'(pos_z[31:0]) * 64'(cfg.cells_per_unit);
    end
    if (state == F_SPLIT) begin
      cell_x  <= split_x.cix;
      cell_z  <= split_z.cix;
      wt_x    <= split_x.wt;
      wt_z    <= split_z.wt;
      clamp_q <= split_x.clamp | split_z.clamp;
    end
  end

endmodule

// ===== hdl/hbs_fifo.sv =====
// ----------------------------------------------------------------------------
// hbs_fifo
// Short job queue between front and back, first in first out.
// ----------------------------------------------------------------------------
module hbs_fifo #(
  parameter int DEPTH = hbs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hbs_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output hbs_pkg::job_t head,
  output logic          empty
);
  import hbs_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== hdl/hbs_back.sv =====
// ----------------------------------------------------------------------------
// hbs_back
// Owns the height grid memory. Writes load jobs, reads the four neighbors
// of a query job one per cycle and blends them in a fixed pipeline.
// ----------------------------------------------------------------------------
module hbs_back #(
  parameter int GRID_SIDE = hbs_pkg::GRID_SIDE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  hbs_pkg::job_t      head,
  output logic               pop,
  output logic               done,
  output logic signed [31:0] height,
  output logic               out_of_range
);
  import hbs_pkg::*;

  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW         = $clog2(GRID_DEPTH);

  back_state_t        state, state_next;
  job_t               ent;
  logic               mem_we;
  logic               issue;
  logic [AW-1:0]      mem_addr;
  logic [31:0]        grid_mem [GRID_DEPTH];
  logic signed [31:0] rdata;
  logic [8:1]         pipe_v;

  logic signed [31:0] p_lo, row_a, r1, r2, r1_d1, r1_d2;
  logic signed [50:0] row_prod, fin_prod;
  logic [WT_W-1:0]    wz_d;
  logic               clamp_d;
  logic signed [32:0] row_diff, fin_diff;
  logic signed [50:0] row_mul, fin_mul;
  logic signed [34:0] row_sum, fin_sum;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty && (head.kind == REQ_QUERY)) begin
          state_next = B_RD1;
        end
      end
      B_RD1:   state_next = B_RD2;
      B_RD2:   state_next = B_RD3;
      B_RD3:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop    = (state == B_IDLE) && !empty;
    mem_we = pop && (head.kind == REQ_LOAD);
    issue  = pop && (head.kind == REQ_QUERY);
    case (state)
      B_IDLE:  mem_addr = head.addr[AW-1:0];
      B_RD1:   mem_addr = ent.addr[AW-1:0] + AW'(1);
      B_RD2:   mem_addr = ent.addr[AW-1:0] + AW'(ent.width);
      B_RD3:   mem_addr = ent.addr[AW-1:0] + AW'(ent.width) + AW'(1);
      default: mem_addr = head.addr[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      pipe_v <= '0;
    end else begin
      state  <= state_next;
      pipe_v <= {pipe_v[7:1], issue};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ent <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= head.data;
    end
    rdata <= grid_mem[mem_addr];
  end

  // a + floor((b - a) * w / 65536), floor by arithmetic shift
  assign row_diff = 33'(rdata) - 33'(p_lo);
  assign row_mul  = 51'(row_diff) * 51'($signed({1'b0, ent.wx}));
  assign row_sum  = 35'(row_a) + 35'($signed(row_prod[50:16]));
  assign fin_diff = 33'(r2) - 33'(r1_d1);
  assign fin_mul  = 51'(fin_diff) * 51'($signed({1'b0, wz_d}));
  assign fin_sum  = 35'(r1_d2) + 35'($signed(fin_prod[50:16]));

  // stage n is enabled by pipe_v[n], the issue strobe shifted along pipe_v;
  // the next query pops after B_RD3, so no stage register is reused too soon
  always_ff @(posedge clk) begin
    if (pipe_v[1]) begin
      p_lo <= rdata;
    end
    if (pipe_v[2]) begin
      row_prod <= row_mul;
      row_a    <= p_lo;
    end
    if (pipe_v[3]) begin
      r1   <= row_sum[31:0];
      p_lo <= rdata;
    end
    if (pipe_v[4]) begin
      row_prod <= row_mul;
      row_a    <= p_lo;
      wz_d     <= ent.wz;
      clamp_d  <= ent.clamped;
    end
    if (pipe_v[5]) begin
      r2    <= row_sum[31:0];
      r1_d1 <= r1;
    end
    if (pipe_v[6]) begin
      fin_prod <= fin_mul;
      r1_d2    <= r1_d1;
    end
    if (pipe_v[7]) begin
      height       <= fin_sum[31:0];
      out_of_range <= clamp_d;
    end
  end

  assign done = pipe_v[8];

endmodule

// ===== hdl/bilinear_heightmap_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_heightmap_sampler_unit
// Height grid with point loads and bilinear height queries at world
// positions; indices past the grid edge are clamped and flagged.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  request   start / busy         req_type, load_index, load_height,
//                                 query_x, query_z
//  result    done (one cycle)     height, out_of_range
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  a query passes the front states accept, multiply, split and push (address),
//  a load accept and push; the back reads the four neighbors through the single
//  grid port and pops no new job until all four reads of a query are issued
//  reset clears control and restores the register defaults; grid contents
//  are undefined until loaded, there is no clearing pass
//  busy stays high while the queue is full; results cannot be held off
//  loads addressed past the grid are dropped
//
module bilinear_heightmap_sampler_unit #(
  parameter int GRID_SIDE   = hbs_pkg::GRID_SIDE_DEFAULT,
  parameter int QUEUE_DEPTH = hbs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [15:0]                    load_index,
  input  logic signed [31:0]             load_height,
  input  logic signed [31:0]             query_x,
  input  logic signed [31:0]             query_z,
  output logic                           done,
  output logic signed [31:0]             height,
  output logic                           out_of_range,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import hbs_pkg::*;

  cfg_t cfg;
  job_t push_job, head_job;
  logic push, full, pop, empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width     <= GRID_WIDTH_RST;
      cfg.half_extent    <= HALF_EXTENT_RST;
      cfg.cells_per_unit <= CELLS_PER_UNIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:     cfg.grid_width     <= cfg_data[8:0];
        REG_HALF_EXTENT:    cfg.half_extent    <= cfg_data[30:0];
        REG_CELLS_PER_UNIT: cfg.cells_per_unit <= cfg_data;
        default:            cfg                <= cfg;
      endcase
    end
  end

  hbs_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .load_index  (load_index),
    .load_height (load_height),
    .query_x     (query_x),
    .query_z     (query_z),
    .cfg         (cfg),
    .push        (push),
    .job         (push_job),
    .full        (full)
  );

  hbs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .full   (full),
    .pop    (pop),
    .head   (head_job),
    .empty  (empty)
  );

  hbs_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head_job),
    .pop          (pop),
    .done         (done),
    .height       (height),
    .out_of_range (out_of_range)
  );

endmodule

// ===== hdl/hbs_checker.sv =====
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the sampler: reset state, front occupancy per query,
// spacing of result beats.
// ----------------------------------------------------------------------------
module hbs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic done
);

  // reset leaves front idle and no result pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("busy or done after reset");

  // an accepted query keeps the front occupied through multiply, split and push
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type) |=> busy ##1 busy ##1 busy)
    else $error("front released early after a query");

  // the grid port keeps result beats apart by the four reads of each query
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done ##1 !done ##1 !done)
    else $error("result beats closer than four cycles");

  // an idle front with no request stays idle
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("busy raised without a request");

endmodule

bind bilinear_heightmap_sampler_unit hbs_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .req_type (req_type),
  .done     (done)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear height-map sampler. A short table of
// directed loads and queries (grid corners, height extremes, clamping below
// and above the grid, exact last sample) is followed by random loads and
// queries over several register settings. A bit-accurate software copy of the
// grid and of the split and blend math predicts each height and clamp flag.
// Grid entries are loaded on demand before a query so no unwritten sample is
// ever read.
// ----------------------------------------------------------------------------
module tb;
  import hbs_pkg::*;

  localparam int SIDE        = GRID_SIDE_DEFAULT;
  localparam int SETTLE      = 24;
  localparam int PHASE_ITEMS = 18;
  localparam int NUM_PHASES  = 8;
  localparam int NUM_ROWS    = 20;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic        req_type    = 1'b0;
  logic [15:0] load_index  = '0;
  logic [31:0] load_height = '0;
  logic [31:0] query_x     = '0;
  logic [31:0] query_z     = '0;
  logic        cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data    = '0;

  logic        busy;
  logic        done;
  logic [31:0] height;
  logic        out_of_range;
  logic        cfg_ready;

  bilinear_heightmap_sampler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .load_index   (load_index),
    .load_height  (load_height),
    .query_x      (query_x),
    .query_z      (query_z),
    .done         (done),
    .height       (height),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [31:0] height;
    logic        oor;
  } sample_t;

  typedef struct packed {
    req_t        kind;
    logic [15:0] idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] z;
    logic        typed;
    logic [31:0] eh;
    logic        eo;
  } row_t;

  // directed rows; expected values typed only where they follow directly
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{REQ_LOAD,  16'd0,     32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{REQ_LOAD,  16'd1,     32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{REQ_LOAD,  16'd256,   32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{REQ_LOAD,  16'd257,   32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    // first sample, no fraction
    '{REQ_QUERY, 16'd0, 32'h0, 32'hFF80_0000, 32'hFF80_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{REQ_QUERY, 16'd0, 32'h0, 32'hFF80_8000, 32'hFF80_0000, 1'b0, 32'h0, 1'b0},
    '{REQ_QUERY, 16'd0, 32'h0, 32'hFF80_8000, 32'hFF80_8000, 1'b0, 32'h0, 1'b0},
    // below the grid on both axes
    '{REQ_QUERY, 16'd0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{REQ_LOAD,  16'd65278, 32'h0000_8000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{REQ_LOAD,  16'd65279, 32'hFFFF_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{REQ_LOAD,  16'd65534, 32'h0003_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{REQ_LOAD,  16'd65535, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    // above the grid gives the far corner sample
    '{REQ_QUERY, 16'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h1234_5678, 1'b1},
    // exactly on the last sample, no flag
    '{REQ_QUERY, 16'd0, 32'h0, 32'h007F_0000, 32'h007F_0000, 1'b1, 32'h1234_5678, 1'b0},
    '{REQ_QUERY, 16'd0, 32'h0, 32'h007F_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{REQ_QUERY, 16'd0, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{REQ_QUERY, 16'd0, 32'h0, 32'h0000_8001, 32'hFFFF_7FFF, 1'b0, 32'h0, 1'b0},
    '{REQ_LOAD,  16'd65535, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{REQ_QUERY, 16'd0, 32'h0, 32'h7FFF_FFFF, 32'h007F_0000, 1'b1, 32'h8000_0000, 1'b1},
    '{REQ_LOAD,  16'd32768, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0}
  };

  // software copy of the block
  logic [31:0] grid_mem [SIDE*SIDE];
  bit          loaded   [SIDE*SIDE];
  logic [8:0]  width_reg = GRID_WIDTH_RST;
  logic [30:0] half_reg  = HALF_EXTENT_RST;
  logic [31:0] scale_reg = CELLS_PER_UNIT_RST;

  sample_t pending_samples[$];
  sample_t head_sample;

  int n_errors  = 0;
  int n_loads   = 0;
  int n_queries = 0;
  int n_flagged = 0;
  int burst_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("[%0t] MISMATCH %s: got %h expected %h", $time, what, got, want);
  endtask

  function automatic int unsigned active_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < 2) w = 2;
    if (w > SIDE) w = SIDE;
    return w;
  endfunction

  // offset, scale and split one coordinate into cell and weight
  function automatic void locate_axis(input logic [31:0] q, input int unsigned w,
                                      output int unsigned cix,
                                      output int unsigned wt, inout bit clamped);
    longint pos;
    longint unsigned p, c, f;
    pos = longint'($signed(q)) + longint'(half_reg);
    if (pos < 0) begin
      p = longint'(-pos) * longint'(scale_reg);
      cix = 0;
      wt = 0;
      if (p != 0) clamped = 1'b1;
    end else begin
      p = longint'(pos) * longint'(scale_reg);
      c = p >> 32;
      f = (p >> 16) & 64'hFFFF;
      if (c < w - 1) begin
        cix = 32'(c);
        wt = 32'(f);
      end else begin
        cix = w - 2;
        wt = 65536;
        if (!(c == w - 1 && f == 0)) clamped = 1'b1;
      end
    end
  endfunction

  function automatic longint blend_q16(input longint a, input longint b,
                                       input int unsigned wt);
    return a + (((b - a) * longint'(wt)) >>> 16);
  endfunction

  function automatic longint sample_at(input int unsigned addr);
    return longint'($signed(grid_mem[addr]));
  endfunction

  function automatic void sample_height(input logic [31:0] x, input logic [31:0] z,
                                        output sample_t res,
                                        output int unsigned base,
                                        output int unsigned w);
    int unsigned cx, cz, wx, wz;
    bit clamped;
    longint r1, r2, h;
    clamped = 1'b0;
    w = active_width();
    locate_axis(x, w, cx, wx, clamped);
    locate_axis(z, w, cz, wz, clamped);
    base = cz * w + cx;
    if (loaded[base] && loaded[base+1] && loaded[base+w] && loaded[base+w+1]) begin
      r1 = blend_q16(sample_at(base), sample_at(base + 1), wx);
      r2 = blend_q16(sample_at(base + w), sample_at(base + w + 1), wx);
      h = blend_q16(r1, r2, wz);
    end else begin
      h = 0;
    end
    res.height = h[31:0];
    res.oor = clamped;
  endfunction

  // holds start high across back-to-back beats, drops it only for a gap
  task automatic send_item(input req_t kind, input logic [15:0] idx,
                           input logic [31:0] val, input logic [31:0] x,
                           input logic [31:0] z, input bit typed,
                           input logic [31:0] eh, input logic eo);
    int unsigned gap;
    int unsigned base, w;
    sample_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start       <= 1'b1;
    req_type    <= kind;
    load_index  <= idx;
    load_height <= val;
    query_x     <= x;
    query_z     <= z;
    do @(posedge clk); while (busy);
    if (kind == REQ_LOAD) begin
      grid_mem[idx] = val;
      loaded[idx] = 1'b1;
      n_loads++;
    end else begin
      sample_height(x, z, res, base, w);
      if (typed) begin
        res.height = eh;
        res.oor = eo;
      end
      pending_samples = {pending_samples, res};
      n_queries++;
    end
  endtask

  // any neighbor not yet written gets a random sample first
  task automatic query_item(input logic [31:0] x, input logic [31:0] z,
                            input bit typed, input logic [31:0] eh, input logic eo);
    int unsigned base, w, addr;
    sample_t res;
    sample_height(x, z, res, base, w);
    for (int k = 0; k < 4; k++) begin
      addr = base + ((k & 1) ? 1 : 0) + ((k & 2) ? w : 0);
      if (!loaded[addr])
        send_item(REQ_LOAD, addr[15:0], $urandom(), 32'h0, 32'h0, 1'b0, 32'h0, 1'b0);
    end
    send_item(REQ_QUERY, 16'h0, 32'h0, x, z, typed, eh, eo);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] w, input logic [31:0] half,
                            input logic [31:0] scale);
    cfg_reg_t r;
    logic [31:0] v;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0:       begin r = REG_GRID_WIDTH;     v = w;     end
        1:       begin r = REG_HALF_EXTENT;    v = half;  end
        default: begin r = REG_CELLS_PER_UNIT; v = scale; end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= v;
      do @(posedge clk); while (!cfg_ready);
      case (r)
        REG_GRID_WIDTH:     width_reg = v[8:0];
        REG_HALF_EXTENT:    half_reg  = v[30:0];
        REG_CELLS_PER_UNIT: scale_reg = v;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // position that lands inside the grid, by inverting offset and scale, else random
  function automatic logic [31:0] grid_coord();
    int unsigned w, t;
    longint q;
    w = active_width();
    t = $urandom_range(0, (w - 1) * 65536);
    if ($urandom_range(0, 3) == 0) t = t & 32'hFFFF_0000;
    if (scale_reg == 0) return $urandom();
    q = (longint'(t) <<< 16) / longint'(scale_reg) - longint'(half_reg);
    if (q < -64'sd2147483648 || q > 64'sd2147483647) return $urandom();
    return q[31:0];
  endfunction

  function automatic logic [31:0] wild_coord();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_items(input int count);
    int unsigned r, w;
    logic [31:0] val, x, z;
    logic [15:0] idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      w = active_width();
      if (r < 25) begin
        idx = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, w * w - 1) : $urandom());
        val = ($urandom_range(0, 7) == 0) ? wild_coord() : $urandom();
        send_item(REQ_LOAD, idx, val, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0);
      end else begin
        x = (r < 85 || $urandom_range(0, 1) == 0) ? grid_coord() : wild_coord();
        z = (r < 85 || $urandom_range(0, 1) == 0) ? grid_coord() : wild_coord();
        query_item(x, z, 1'b0, 32'h0, 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("result with nothing pending", height, 32'h0);
      end else begin
        head_sample = pending_samples.pop_front();
        if (height !== head_sample.height)
          report_mismatch("height", height, head_sample.height);
        if (out_of_range !== head_sample.oor)
          report_mismatch("out_of_range", 32'(out_of_range), 32'(head_sample.oor));
        if (out_of_range === 1'b1) n_flagged++;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("bilinear_heightmap_sampler_unit verification failed");
    $finish;
  end

  initial begin
    logic [31:0] pw, ph, ps;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < NUM_ROWS; k++) begin
      if (DIRECTED[k].kind == REQ_LOAD)
        send_item(REQ_LOAD, DIRECTED[k].idx, DIRECTED[k].val, 32'h0, 32'h0,
                  1'b0, 32'h0, 1'b0);
      else
        query_item(DIRECTED[k].x, DIRECTED[k].z, DIRECTED[k].typed,
                   DIRECTED[k].eh, DIRECTED[k].eo);
    end
    random_items(PHASE_ITEMS);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin pw = 8;   ph = 32'h0004_0000; ps = 32'h0001_0000; end
        1: begin pw = 2;   ph = 32'h0001_0000; ps = 32'h0000_8000; end
        // widths below two and above the grid side saturate
        2: begin pw = 0;   ph = 32'h0;         ps = 32'h0001_0000; end
        3: begin pw = 1;   ph = 32'h7FFF_FFFF; ps = 32'h0;         end
        4: begin pw = 511; ph = 32'h0;         ps = 32'hFFFF_FFFF; end
        5: begin pw = 16;  ph = 32'h0008_0000; ps = 32'h0001_8000; end
        6: begin pw = 256; ph = 32'h0080_0000; ps = 32'h0001_0000; end
        default: begin
          pw = $urandom_range(2, 40);
          ph = $urandom_range(0, 64) << 16;
          ps = $urandom_range(32'h4000, 32'h4_0000);
        end
      endcase
      drain();
      set_config(pw, ph, ps);
      random_items(PHASE_ITEMS);
    end

    drain();
    $display("covered %0d loads and %0d queries (%0d clamped) over %0d settings",
             n_loads, n_queries, n_flagged, NUM_PHASES + 1);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("bilinear_heightmap_sampler_unit verification clean");
    end else begin
      $display("bilinear_heightmap_sampler_unit verification failed");
    end
    $finish;
  end

endmodule
